// ===== design/bwds_pkg.sv =====
// Shared types, codes and helpers for the burn wire deploy sequencer.
`timescale 1ns / 1ps
package bwds_pkg;

	localparam int CONTACT_SAMPLES = 5;
	localparam int DUTY_FULL       = 100;
	localparam int DUTY_W          = 7;
	localparam int COUNT_W         = 16;
	localparam int CFG_INDEX_W     = 3;

	typedef logic [DUTY_W-1:0]          duty_t;
	typedef logic [COUNT_W-1:0]         count_t;
	typedef logic [CONTACT_SAMPLES-1:0] win_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_SP_BURN  = 3'd1,
		ST_SP_COOL  = 3'd2,
		ST_FP_BURN  = 3'd3,
		ST_FP_COOL  = 3'd4,
		ST_SP_FIXED = 3'd5,
		ST_FP_FIXED = 3'd6
	} seq_state_t;

	// Deploy plans chosen at command time
	typedef enum logic [2:0] {
		PLAN_BOTH      = 3'd0,
		PLAN_SP_SINGLE = 3'd1,
		PLAN_FP_SINGLE = 3'd2,
		PLAN_DEF_BOTH  = 3'd3,
		PLAN_FP_DEF    = 3'd4,
		PLAN_SP_DEF    = 3'd5
	} plan_t;

	// Command codes
	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_DEPLOY_BOTH = 2'd1,
		OP_DEPLOY_FP = 2'd2,
		OP_DEPLOY_SP = 2'd3
	} op_t;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_INIT_DUTY        = 3'd0,
		CFG_DUTY_STEP        = 3'd1,
		CFG_FALLBACK_DUTY    = 3'd2,
		CFG_BEST_MARGIN      = 3'd3,
		CFG_BURN_PERIODS     = 3'd4,
		CFG_COOLDOWN_PERIODS = 3'd5,
		CFG_TICKS_PER_PHASE  = 3'd6,
		CFG_UNUSED           = 3'd7
	} cfg_idx_t;

	// Configuration values seen by the sequencer
	typedef struct packed {
		duty_t       duty_step;
		duty_t       fallback_duty;
		duty_t       best_margin;
		count_t      burn_periods;
		count_t      cooldown_periods;
		count_t      ticks_per_phase;
	} cfg_regs_t;

	// Initial duty reload request from the register bank
	typedef struct packed {
		logic  load;
		duty_t value;
	} duty_load_t;

	// One input request
	typedef struct packed {
		logic [1:0] op;
		logic       sp_contact_pin;
		logic       fp_contact_pin;
		logic       abort;
	} in_item_t;

	// One result request
	typedef struct packed {
		logic       sp_drive;
		logic       fp_drive;
		logic       busy_res;
		logic       done_res;
		logic [3:0] status_flags;
		duty_t      sp_duty_recorded;
		duty_t      fp_duty_recorded;
		logic       sp_error;
		logic       fp_error;
		logic       error_event;
		logic [1:0] contact_now;
	} out_item_t;

	// Duty plus an increment, capped at full duty
	function automatic duty_t capped_add(input duty_t d, input duty_t a);
		logic [DUTY_W:0] s;
		s = {1'b0, d} + {1'b0, a};
		return (s >= (DUTY_W+1)'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL) : s[DUTY_W-1:0];
	endfunction

endpackage

// ===== design/bwds_cfg_regs.sv =====
// Configuration register bank of the burn wire deploy sequencer.
`timescale 1ns / 1ps
module bwds_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [bwds_pkg::CFG_INDEX_W-1:0]   wr_index,
	input  logic [bwds_pkg::COUNT_W-1:0]       wr_data,
	output bwds_pkg::cfg_regs_t                cfg,
	output bwds_pkg::duty_load_t               duty_load
);
	import bwds_pkg::*;

	duty_t  duty_step_q, fallback_duty_q, best_margin_q;
	count_t burn_periods_q, cooldown_periods_q, ticks_per_phase_q;
	logic   [5:0] step_field;

	assign step_field = wr_data[5:0];

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_step_q        <= DUTY_W'(5);
			fallback_duty_q    <= DUTY_W'(30);
			best_margin_q      <= DUTY_W'(15);
			burn_periods_q     <= COUNT_W'(300);
			cooldown_periods_q <= COUNT_W'(500);
			ticks_per_phase_q  <= COUNT_W'(100);
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_DUTY_STEP:        duty_step_q        <= {1'b0, step_field};
				CFG_FALLBACK_DUTY:    fallback_duty_q    <= wr_data[DUTY_W-1:0];
				CFG_BEST_MARGIN:      best_margin_q      <= wr_data[DUTY_W-1:0];
				CFG_BURN_PERIODS:     burn_periods_q     <= wr_data;
				CFG_COOLDOWN_PERIODS: cooldown_periods_q <= wr_data;
				CFG_TICKS_PER_PHASE:  ticks_per_phase_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Initial duty is not kept here: a write reloads both probe duties
	assign duty_load.load  = wr_en && (cfg_idx_t'(wr_index) == CFG_INIT_DUTY);
	assign duty_load.value = wr_data[DUTY_W-1:0];

	assign cfg.duty_step        = duty_step_q;
	assign cfg.fallback_duty    = fallback_duty_q;
	assign cfg.best_margin      = best_margin_q;
	assign cfg.burn_periods     = burn_periods_q;
	assign cfg.cooldown_periods = cooldown_periods_q;
	assign cfg.ticks_per_phase  = ticks_per_phase_q;

endmodule

// ===== design/bwds_contact.sv =====
// Contact pin sample windows for both probes.
`timescale 1ns / 1ps
module bwds_contact (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       sp_pin,
	input  logic       fp_pin,
	output logic [1:0] contact
);
	import bwds_pkg::*;

	win_t sp_win_q, fp_win_q;
	win_t sp_nxt, fp_nxt;

	// Shift in this tick's sample; contact if any sample is low
	assign sp_nxt  = win_t'({sp_win_q, sp_pin});
	assign fp_nxt  = win_t'({fp_win_q, fp_pin});
	assign contact = {fp_nxt != '1, sp_nxt != '1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_win_q <= '1;
			fp_win_q <= '1;
		end else if (adv) begin
			sp_win_q <= sp_nxt;
			fp_win_q <= fp_nxt;
		end
	end

endmodule

// ===== design/bwds_seq.sv =====
// Deploy sequencer: plan selection, PWM counters, adaptive and fixed burns.
`timescale 1ns / 1ps
module bwds_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  bwds_pkg::in_item_t    item,
	input  logic [1:0]            contact,
	input  bwds_pkg::cfg_regs_t   cfg,
	input  bwds_pkg::duty_load_t  duty_load,
	output bwds_pkg::out_item_t   res
);
	import bwds_pkg::*;

	seq_state_t state_q, n_state, enter_st;
	plan_t      plan_q, n_plan;
	count_t     pre_q, n_pre, period_q, n_period;
	duty_t      phase_q, n_phase;
	duty_t      sp_duty_q, n_sp_duty, fp_duty_q, n_fp_duty;
	duty_t      sp_rec_q, n_sp_rec, fp_rec_q, n_fp_rec;
	logic [3:0] flags_q, n_flags;
	logic [1:0] err_q, n_err;

	logic       done, err_ev, enter_req;
	logic [1:0] drive;
	logic       do_start, start_p, do_end, end_p, end_ok, do_fixed_end, fix_p;

	// Advanced counter values
	count_t            tp;
	logic [COUNT_W:0]  pre_inc;
	duty_t             phase_inc;
	count_t            a_pre, a_period;
	duty_t             a_phase;
	logic              burn_over, cool_over;

	// PWM prescaler, phase and saturating period count
	always_comb begin
		tp        = (cfg.ticks_per_phase == '0) ? COUNT_W'(1) : cfg.ticks_per_phase;
		pre_inc   = {1'b0, pre_q} + (COUNT_W+1)'(1);
		phase_inc = phase_q + DUTY_W'(1);
		a_pre     = pre_q;
		a_phase   = phase_q;
		a_period  = period_q;
		if (pre_inc >= {1'b0, tp}) begin
			a_pre = '0;
			if (phase_inc >= DUTY_W'(DUTY_FULL)) begin
				a_phase = '0;
				if (period_q != '1)
					a_period = period_q + COUNT_W'(1);
			end else begin
				a_phase = phase_inc;
			end
		end else begin
			a_pre = pre_inc[COUNT_W-1:0];
		end
		burn_over = a_period >= cfg.burn_periods;
		cool_over = a_period >= cfg.cooldown_periods;
	end

	// Next state for one tick
	always_comb begin
		n_state = state_q;  n_plan = plan_q;
		n_pre = pre_q;  n_phase = phase_q;  n_period = period_q;
		n_sp_duty = sp_duty_q;  n_fp_duty = fp_duty_q;
		n_sp_rec = sp_rec_q;  n_fp_rec = fp_rec_q;
		n_flags = flags_q;  n_err = err_q;
		done = 1'b0;  err_ev = 1'b0;  drive = 2'b00;
		enter_req = 1'b0;  enter_st = ST_IDLE;
		do_start = 1'b0;  start_p = 1'b0;
		do_end = 1'b0;  end_p = 1'b0;  end_ok = 1'b0;
		do_fixed_end = 1'b0;  fix_p = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				unique case (op_t'(item.op))
					OP_DEPLOY_BOTH: begin
						if (contact[0]) begin
							n_flags[2] = 1'b1;
							if (contact[1]) begin
								n_flags[3] = 1'b1;
								n_plan = PLAN_BOTH;
							end else begin
								n_plan = PLAN_SP_SINGLE;
							end
							do_start = 1'b1;  start_p = 1'b0;
						end else if (contact[1]) begin
							n_flags[3] = 1'b1;
							n_plan = PLAN_FP_SINGLE;
							do_start = 1'b1;  start_p = 1'b1;
						end else begin
							n_plan = PLAN_DEF_BOTH;
							n_sp_duty = cfg.fallback_duty;
							enter_req = 1'b1;  enter_st = ST_SP_FIXED;
						end
					end
					OP_DEPLOY_FP: begin
						if (contact[1]) begin
							n_flags[3] = 1'b1;
							n_plan = PLAN_FP_SINGLE;
							do_start = 1'b1;  start_p = 1'b1;
						end else begin
							n_plan = PLAN_FP_DEF;
							n_fp_duty = cfg.fallback_duty;
							enter_req = 1'b1;  enter_st = ST_FP_FIXED;
						end
					end
					OP_DEPLOY_SP: begin
						if (contact[0]) begin
							n_flags[2] = 1'b1;
							n_plan = PLAN_SP_SINGLE;
							do_start = 1'b1;  start_p = 1'b0;
						end else begin
							n_plan = PLAN_SP_DEF;
							n_sp_duty = cfg.fallback_duty;
							enter_req = 1'b1;  enter_st = ST_SP_FIXED;
						end
					end
					OP_TICK: ;
				endcase
			end
			ST_SP_BURN, ST_FP_BURN: begin
				end_p = (state_q == ST_FP_BURN);
				if (item.abort) begin
					if (end_p) n_fp_duty = capped_add(fp_duty_q, cfg.duty_step);
					else       n_sp_duty = capped_add(sp_duty_q, cfg.duty_step);
					do_end = 1'b1;  end_ok = 1'b0;
				end else if (!contact[end_p]) begin
					do_end = 1'b1;  end_ok = 1'b1;
				end else begin
					drive[end_p] = phase_q < (end_p ? fp_duty_q : sp_duty_q);
					n_pre = a_pre;  n_phase = a_phase;  n_period = a_period;
					if (burn_over) begin
						if (end_p) n_fp_duty = capped_add(fp_duty_q, cfg.duty_step);
						else       n_sp_duty = capped_add(sp_duty_q, cfg.duty_step);
						enter_req = 1'b1;
						enter_st  = end_p ? ST_FP_COOL : ST_SP_COOL;
					end
				end
			end
			ST_SP_COOL, ST_FP_COOL: begin
				end_p = (state_q == ST_FP_COOL);
				if (item.abort) begin
					do_end = 1'b1;  end_ok = 1'b0;
				end else begin
					n_pre = a_pre;  n_phase = a_phase;  n_period = a_period;
					if (cool_over) begin
						if ((end_p ? fp_duty_q : sp_duty_q) < DUTY_W'(DUTY_FULL)) begin
							enter_req = 1'b1;
							enter_st  = end_p ? ST_FP_BURN : ST_SP_BURN;
						end else begin
							do_end = 1'b1;  end_ok = 1'b0;
						end
					end
				end
			end
			ST_SP_FIXED, ST_FP_FIXED: begin
				fix_p = (state_q == ST_FP_FIXED);
				if (item.abort) begin
					do_fixed_end = 1'b1;
				end else begin
					drive[fix_p] = phase_q < (fix_p ? fp_duty_q : sp_duty_q);
					n_pre = a_pre;  n_phase = a_phase;  n_period = a_period;
					if (burn_over)
						do_fixed_end = 1'b1;
				end
			end
			default: n_state = ST_IDLE;
		endcase

		// Adaptive start: a probe already at full duty fails at once
		if (do_start) begin
			if ((start_p ? n_fp_duty : n_sp_duty) < DUTY_W'(DUTY_FULL)) begin
				enter_req = 1'b1;
				enter_st  = start_p ? ST_FP_BURN : ST_SP_BURN;
			end else begin
				do_end = 1'b1;  end_p = start_p;  end_ok = 1'b0;
			end
		end

		// End of a fixed burn: deployed even on abort
		if (do_fixed_end) begin
			n_flags[{1'b0, fix_p}] = 1'b1;
			if (fix_p) n_fp_rec = n_fp_duty;
			else       n_sp_rec = n_sp_duty;
			if (n_plan == PLAN_DEF_BOTH && !fix_p) begin
				n_fp_duty = cfg.fallback_duty;
				enter_req = 1'b1;  enter_st = ST_FP_FIXED;
			end else begin
				n_state = ST_IDLE;  done = 1'b1;
			end
		end

		// End of an adaptive burn
		if (do_end) begin
			if (n_plan == PLAN_BOTH) begin
				if (end_p) n_fp_rec = n_fp_duty;
				else       n_sp_rec = n_sp_duty;
				if (end_ok) begin
					n_flags[{1'b0, end_p}] = 1'b1;
				end else begin
					n_err[end_p] = 1'b1;  err_ev = 1'b1;
				end
				if (!end_p) begin
					if (n_fp_duty < DUTY_W'(DUTY_FULL)) begin
						enter_req = 1'b1;  enter_st = ST_FP_BURN;
					end else begin
						// floating probe already at full duty: fails unburnt
						n_fp_rec = n_fp_duty;
						n_err[1] = 1'b1;  err_ev = 1'b1;
						n_state = ST_IDLE;  done = 1'b1;
					end
				end else begin
					n_state = ST_IDLE;  done = 1'b1;
				end
			end else if (!end_ok) begin
				n_err = 2'b11;  err_ev = 1'b1;
				n_state = ST_IDLE;  done = 1'b1;
			end else begin
				n_flags[{1'b0, end_p}] = 1'b1;
				if (end_p) begin
					n_fp_rec  = n_fp_duty;
					n_sp_duty = capped_add(n_fp_duty, cfg.best_margin);
					enter_req = 1'b1;  enter_st = ST_SP_FIXED;
				end else begin
					n_sp_rec  = n_sp_duty;
					n_fp_duty = capped_add(n_sp_duty, cfg.best_margin);
					enter_req = 1'b1;  enter_st = ST_FP_FIXED;
				end
			end
		end

		// Entering a timed state restarts the PWM counters
		if (enter_req) begin
			n_state = enter_st;
			n_pre = '0;  n_phase = '0;  n_period = '0;
		end
	end

	// State registers, advanced once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			plan_q   <= PLAN_BOTH;
			pre_q    <= '0;
			phase_q  <= '0;
			period_q <= '0;
			sp_duty_q <= DUTY_W'(30);
			fp_duty_q <= DUTY_W'(30);
			sp_rec_q <= '0;
			fp_rec_q <= '0;
			flags_q  <= '0;
			err_q    <= '0;
		end else begin
			if (duty_load.load) begin
				sp_duty_q <= duty_load.value;
				fp_duty_q <= duty_load.value;
			end else if (adv) begin
				sp_duty_q <= n_sp_duty;
				fp_duty_q <= n_fp_duty;
			end
			if (adv) begin
				state_q  <= n_state;
				plan_q   <= n_plan;
				pre_q    <= n_pre;
				phase_q  <= n_phase;
				period_q <= n_period;
				sp_rec_q <= n_sp_rec;
				fp_rec_q <= n_fp_rec;
				flags_q  <= n_flags;
				err_q    <= n_err;
			end
		end
	end

	// Result of this tick
	assign res.sp_drive         = drive[0];
	assign res.fp_drive         = drive[1];
	assign res.busy_res         = (n_state != ST_IDLE);
	assign res.done_res         = done;
	assign res.status_flags     = n_flags;
	assign res.sp_duty_recorded = n_sp_rec;
	assign res.fp_duty_recorded = n_fp_rec;
	assign res.sp_error         = n_err[0];
	assign res.fp_error         = n_err[1];
	assign res.error_event      = err_ev;
	assign res.contact_now      = contact;

endmodule

// ===== design/burn_wire_deploy_sequencer.sv =====
// Top level of the burn wire deploy sequencer: request pipeline and config port.
`timescale 1ns / 1ps
// Each input request is one timer tick and yields exactly one result request.
// A tick is taken every clock while the result side keeps up. It is held in the
// input register and moves into the result register once that register is free
// or being drained, and its result is presented from the result register; the
// sequencer state advances as the tick moves into the result register. A stalled
// result holds the input register and so stalls the input.
// Contact on a probe means any of its last five pin samples read low. Burn
// length is burn_periods PWM periods of 100 phase steps of ticks_per_phase
// ticks each, so timing is counted in ticks, not clocks. Configuration is
// written over its own port, always ready, and should only be written while
// no request is in flight; writing the initial duty register reloads both
// probe duties.
module burn_wire_deploy_sequencer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  bwds_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output bwds_pkg::out_item_t              out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bwds_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bwds_pkg::COUNT_W-1:0]     cfg_data
);
	import bwds_pkg::*;

	logic       valid_s1;
	in_item_t   item_s1;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       adv;
	logic [1:0] contact;
	cfg_regs_t  cfg;
	duty_load_t duty_load;
	out_item_t  res;

	// Tick moves on when the result register is free or being drained
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	assign cfg_ready = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			item_s1 <= in_data;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	bwds_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_valid && cfg_ready),
		.wr_index  (cfg_index),
		.wr_data   (cfg_data),
		.cfg       (cfg),
		.duty_load (duty_load)
	);

	bwds_contact u_contact (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.sp_pin  (item_s1.sp_contact_pin),
		.fp_pin  (item_s1.fp_contact_pin),
		.contact (contact)
	);

	bwds_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item      (item_s1),
		.contact   (contact),
		.cfg       (cfg),
		.duty_load (duty_load),
		.res       (res)
	);

	// Only one wire burns at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.sp_drive && out_data.fp_drive))
		else $error("both burn wires driven");

	// The ending tick of a sequence reports idle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done pulse while still busy");

	// An error pulse always leaves a sticky error bit behind
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_event |-> (out_data.sp_error || out_data.fp_error))
		else $error("error pulse without sticky error");

endmodule
